[hw/rtl/cursor_text_line_buffer_core_assert.svh]
// Assertion macros used by the line buffer checker.
`ifndef CURSOR_TEXT_LINE_BUFFER_CORE_ASSERT_SVH
`define CURSOR_TEXT_LINE_BUFFER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CTLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CTLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ctlb_pkg.sv]
// Shared types and constants of the cursor text line buffer.
`default_nettype none

package ctlb_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned CHAR_W    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 4'd0,
    CMD_INSERT = 4'd1,
    CMD_BKSP   = 4'd2,
    CMD_DELETE = 4'd3,
    CMD_LEFT   = 4'd4,
    CMD_RIGHT  = 4'd5,
    CMD_HOME   = 4'd6,
    CMD_END    = 4'd7,
    CMD_READ   = 4'd8
  } cmd_t;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_BKSP,
    CELL_COMPACT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic [CHAR_W-1:0] data;
    logic              keep;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/ctlb_cell.sv]
// One byte cell of the text chain; shifts with its neighbors on edits.
`default_nettype none

module ctlb_cell import ctlb_pkg::*; #(
  parameter int unsigned    AW  = 6,
  parameter logic [AW-1:0]  IDX = '0
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [AW-1:0]     pos,
  input  wire logic [CHAR_W-1:0] left_q,
  input  wire logic [CHAR_W-1:0] right_q,
  output logic      [CHAR_W-1:0] q
);

  logic [CHAR_W-1:0] q_r;
  logic [CHAR_W-1:0] q_nxt;

  // Pick the next byte from the broadcast command and this cell's place
  always_comb begin
    q_nxt = q_r;
    case (ctl.mode)
      CELL_INSERT: begin
        if (IDX > pos) begin
          q_nxt = left_q;
        end else if (IDX == pos) begin
          q_nxt = ctl.data;
        end
      end
      CELL_BKSP: begin
        if (IDX >= pos) begin
          q_nxt = right_q;
        end
      end
      CELL_COMPACT: begin
        // Pop the head: everyone moves left, a kept byte lands at the tail
        if (ctl.keep && (IDX == pos)) begin
          q_nxt = ctl.data;
        end else begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

[hw/rtl/ctlb_ctrl.sv]
// Command sequencer: length, cursor, compaction steps and the result register.
`default_nettype none

module ctlb_ctrl import ctlb_pkg::*; #(
  parameter  int unsigned BUFFER_DEPTH = DEPTH_DEF,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH),
  localparam int unsigned LW = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [CHAR_W-1:0] in_char,
  input  wire logic [AW-1:0]     in_idx,
  input  wire logic [CHAR_W-1:0] head_byte,
  input  wire logic [CHAR_W-1:0] sel_byte,
  output cell_ctl_t              ctl,
  output logic      [AW-1:0]     pos,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [LW-1:0]     out_len,
  output logic      [LW-1:0]     out_cur,
  output logic                   out_rej,
  output logic      [CHAR_W-1:0] out_byte,
  output logic                   out_rv
);

  state_t            state_r,     state_nxt;
  logic [LW-1:0]     len_r,       len_nxt;
  logic [LW-1:0]     cur_r,       cur_nxt;
  logic [LW-1:0]     rem_r,       rem_nxt;
  logic [LW-1:0]     ahead_r,     ahead_nxt;
  logic [CHAR_W-1:0] ch_r,        ch_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              rej_r,       rej_nxt;
  logic [CHAR_W-1:0] byte_r,      byte_nxt;
  logic              rv_r,        rv_nxt;

  logic              accept;
  logic              full;
  logic              keep;
  logic [LW-1:0]     len_dec;
  logic [LW-1:0]     cur_dec;
  cmd_t              cmd;

  assign cmd     = cmd_t'(in_cmd);
  assign accept  = in_tvalid && in_tready;
  assign full    = (len_r == LW'(BUFFER_DEPTH));
  assign keep    = (head_byte != ch_r);
  assign len_dec = len_r - LW'(1);
  assign cur_dec = cur_r - LW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (cmd == CMD_DELETE) && (len_r != '0)) begin
          state_nxt = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (rem_r == LW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and cell chain commands
  always_comb begin
    in_tready = 1'b0;
    ctl.mode  = CELL_HOLD;
    ctl.data  = in_char;
    ctl.keep  = 1'b0;
    pos       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              if (!full) begin
                ctl.mode = CELL_INSERT;
                pos      = cur_r[AW-1:0];
              end
            end
            CMD_BKSP: begin
              if (cur_r != '0) begin
                ctl.mode = CELL_BKSP;
                pos      = cur_dec[AW-1:0];
              end
            end
            default: ctl.mode = CELL_HOLD;
          endcase
        end
      end
      ST_COMPACT: begin
        ctl.mode = CELL_COMPACT;
        ctl.data = head_byte;
        ctl.keep = keep;
        pos      = len_dec[AW-1:0];
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Length, cursor, step counters and result fields
  always_comb begin
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    ahead_nxt     = ahead_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    rej_nxt       = rej_r;
    byte_nxt      = byte_r;
    rv_nxt        = rv_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      rej_nxt       = 1'b0;
      byte_nxt      = '0;
      rv_nxt        = 1'b0;
      case (cmd)
        CMD_CLEAR: begin
          len_nxt = '0;
          cur_nxt = '0;
        end
        CMD_INSERT: begin
          if (full) begin
            rej_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LW'(1);
            cur_nxt = cur_r + LW'(1);
          end
        end
        CMD_BKSP: begin
          if (cur_r != '0) begin
            len_nxt = len_dec;
            cur_nxt = cur_dec;
          end
        end
        CMD_DELETE: begin
          ch_nxt    = in_char;
          rem_nxt   = len_r;
          ahead_nxt = cur_r;
          if (len_r != '0) begin
            out_valid_nxt = 1'b0;
          end
        end
        CMD_LEFT: begin
          if (cur_r != '0) begin
            cur_nxt = cur_dec;
          end
        end
        CMD_RIGHT: begin
          if (cur_r < len_r) begin
            cur_nxt = cur_r + LW'(1);
          end
        end
        CMD_HOME: cur_nxt = '0;
        CMD_END:  cur_nxt = len_r;
        CMD_READ: begin
          if (LW'(in_idx) < len_r) begin
            rv_nxt   = 1'b1;
            byte_nxt = sel_byte;
          end
        end
        default: len_nxt = len_r;
      endcase
    end else if (state_r == ST_COMPACT) begin
      // One byte leaves the head per cycle; a kept one returns at the tail
      if (!keep) begin
        len_nxt = len_dec;
      end
      rem_nxt = rem_r - LW'(1);
      if (ahead_r != '0) begin
        ahead_nxt = ahead_r - LW'(1);
        if (!keep) begin
          cur_nxt = cur_dec;
        end
      end
      if (rem_r == LW'(1)) begin
        out_valid_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      rem_r       <= '0;
      ahead_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      rem_r       <= rem_nxt;
      ahead_r     <= ahead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    rej_r  <= rej_nxt;
    byte_r <= byte_nxt;
    rv_r   <= rv_nxt;
  end

  // Length and cursor hold while a result waits to be taken
  assign out_tvalid = out_valid_r;
  assign out_len    = len_r;
  assign out_cur    = cur_r;
  assign out_rej    = rej_r;
  assign out_byte   = byte_r;
  assign out_rv     = rv_r;

endmodule

`default_nettype wire

[hw/rtl/cursor_text_line_buffer_core.sv]
// Results: every command but delete-all answers in the cycle after its transfer;
// delete-all on a nonempty text first compacts it, one byte per cycle through the head cell.
// Throughput: one command per cycle while results are taken; delete-all holds
// off input until its compaction pass through the cell chain ends.
// Reset: length and cursor go to zero; text cells keep their contents.
`default_nettype none

module cursor_text_line_buffer_core import ctlb_pkg::*; #(
  parameter  int unsigned BUFFER_DEPTH = DEPTH_DEF,
  localparam int unsigned AW    = $clog2(BUFFER_DEPTH),
  localparam int unsigned LW    = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned IN_W  = ((CMD_W + CHAR_W + AW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * LW + CHAR_W + 2 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // command, char_value, read_index
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // text_length, cursor_pos, rejected, read_byte, read_valid
  output logic      [OUT_W-1:0] out_tdata
);

  logic [CMD_W-1:0]  in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic [AW-1:0]     in_idx;
  logic [CHAR_W-1:0] cell_q [BUFFER_DEPTH];
  logic [CHAR_W-1:0] sel_byte;
  cell_ctl_t         ctl;
  logic [AW-1:0]     pos;
  logic [LW-1:0]     out_len;
  logic [LW-1:0]     out_cur;
  logic              out_rej;
  logic [CHAR_W-1:0] out_byte;
  logic              out_rv;

  // Unpack the command transfer
  assign in_cmd  = in_tdata[CMD_W-1:0];
  assign in_char = in_tdata[CMD_W+CHAR_W-1:CMD_W];
  assign in_idx  = in_tdata[CMD_W+CHAR_W+AW-1:CMD_W+CHAR_W];

  // Byte at the read index
  assign sel_byte = cell_q[in_idx];

  ctlb_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_cmd),
    .in_char   (in_char),
    .in_idx    (in_idx),
    .head_byte (cell_q[0]),
    .sel_byte  (sel_byte),
    .ctl       (ctl),
    .pos       (pos),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_len   (out_len),
    .out_cur   (out_cur),
    .out_rej   (out_rej),
    .out_byte  (out_byte),
    .out_rv    (out_rv)
  );

  // Chain of byte cells, each wired to its neighbors (an end cell to itself on its open side)
  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    localparam int unsigned LI = (i == 0) ? 0 : i - 1;
    localparam int unsigned RI = (i == BUFFER_DEPTH - 1) ? i : i + 1;
    ctlb_cell #(
      .AW (AW),
      .IDX(AW'(i))
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .pos    (pos),
      .left_q (cell_q[LI]),
      .right_q(cell_q[RI]),
      .q      (cell_q[i])
    );
  end

  // Pack the result transfer
  assign out_tdata = OUT_W'({out_rv, out_byte, out_rej, out_cur, out_len});

endmodule

`default_nettype wire

[hw/rtl/ctlb_checker.sv]
// Port-level checks of the line buffer, bound to the top level.
`default_nettype none

`include "cursor_text_line_buffer_core_assert.svh"

module ctlb_checker import ctlb_pkg::*; #(
  parameter  int unsigned BUFFER_DEPTH = DEPTH_DEF,
  localparam int unsigned AW    = $clog2(BUFFER_DEPTH),
  localparam int unsigned LW    = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned IN_W  = ((CMD_W + CHAR_W + AW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * LW + CHAR_W + 2 + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [IN_W-1:0]  in_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  logic [LW-1:0]     o_len;
  logic [LW-1:0]     o_cur;
  logic              o_rej;
  logic [CHAR_W-1:0] o_byte;
  logic              o_rv;
  logic              out_stall;
  logic              res_ok;
  logic              quick_cmd;

  assign o_len     = out_tdata[LW-1:0];
  assign o_cur     = out_tdata[2*LW-1:LW];
  assign o_rej     = out_tdata[2*LW];
  assign o_byte    = out_tdata[2*LW+CHAR_W:2*LW+1];
  assign o_rv      = out_tdata[2*LW+CHAR_W+1];
  assign out_stall = out_tvalid && !out_tready;
  // Cursor within the text, and a zero byte unless the read was valid
  assign res_ok    = (o_cur <= o_len) && (o_rv || (o_byte == '0));
  // Every command but delete-all answers in the next cycle
  assign quick_cmd = in_tvalid && in_tready && (in_tdata[CMD_W-1:0] != CMD_DELETE);

  // A stalled result holds
  `CTLB_ASSERT_NEXT(a_result_hold, out_stall, out_tvalid && $stable(out_tdata), "result changed")

  // No new command while a result waits
  `CTLB_ASSERT_NOW(a_no_accept_stalled, out_stall, !in_tready, "input open while stalled")

  // Cursor never passes the end of the text; invalid read shows a zero byte
  `CTLB_ASSERT_NOW(a_result_fields, out_tvalid, res_ok, "bad cursor or read byte")

  // Refusal only with a full buffer
  `CTLB_ASSERT_NOW(a_reject_full, out_tvalid && o_rej, o_len == LW'(BUFFER_DEPTH), "early refusal")

  // Single-step commands produce their result in the cycle after the transfer
  `CTLB_ASSERT_NEXT(a_quick_result, quick_cmd, out_tvalid, "result late")

endmodule

bind cursor_text_line_buffer_core ctlb_checker #(
  .BUFFER_DEPTH(BUFFER_DEPTH)
) u_ctlb_checker (.*);

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the cursor line edit buffer: command stream, predictor, result checks.
`default_nettype none

module tb;
  import ctlb_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(DEPTH + 1);
  localparam int unsigned IN_W  = ((CMD_W + CHAR_W + AW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2 * LW + CHAR_W + 2 + 7) / 8) * 8;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned RANDOM_CMDS = 700;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 40;

  // Stimulus flavors of the random part
  typedef enum int {
    MODE_TYPE,
    MODE_FILL,
    MODE_EDIT
  } stim_mode_t;

  // Result word, last member in the lowest bits to match out_tdata
  typedef struct packed {
    logic              read_ok;
    logic [CHAR_W-1:0] byte_read;
    logic              refused;
    logic [LW-1:0]     cursor;
    logic [LW-1:0]     length;
  } edit_status_t;

  // Line buffer predictor plus queue of pending status words
  class line_edit_tracker;
    logic [CHAR_W-1:0] text_mem [DEPTH];
    int unsigned       fill;
    int unsigned       cursor;
    edit_status_t      expected_status[$];
    int unsigned       errors;
    int unsigned       results_seen;
    int unsigned       refused_cnt;
    int unsigned       valid_reads;
    int unsigned       purge_hits;
    int unsigned       peak_fill;

    function new();
      fill         = 0;
      cursor       = 0;
      errors       = 0;
      results_seen = 0;
      refused_cnt  = 0;
      valid_reads  = 0;
      purge_hits   = 0;
      peak_fill    = 0;
    endfunction

    // Apply one accepted command and queue the status it must produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                               logic [AW-1:0] idx);
      edit_status_t st;
      int unsigned  i;
      int unsigned  wr;
      int unsigned  removed_before;
      st = '0;
      case (cmd)
        CMD_CLEAR: begin
          fill   = 0;
          cursor = 0;
        end
        CMD_INSERT: begin
          if (fill >= DEPTH) begin
            st.refused = 1'b1;
            refused_cnt++;
          end else begin
            // open a slot at the cursor
            for (i = fill; i > cursor; i--) text_mem[i] = text_mem[i - 1];
            text_mem[cursor] = ch;
            fill++;
            cursor++;
          end
        end
        CMD_BKSP: begin
          if (cursor != 0) begin
            // close the gap left of the cursor
            for (i = cursor - 1; i + 1 < fill; i++) text_mem[i] = text_mem[i + 1];
            cursor--;
            fill--;
          end
        end
        CMD_DELETE: begin
          wr             = 0;
          removed_before = 0;
          // compact, pulling the cursor left for each hit ahead of it
          for (i = 0; i < fill; i++) begin
            if (text_mem[i] == ch) begin
              if (i < cursor) removed_before++;
            end else begin
              text_mem[wr] = text_mem[i];
              wr++;
            end
          end
          if (wr != fill) purge_hits++;
          fill   = wr;
          cursor = (cursor >= removed_before) ? cursor - removed_before : 0;
          if (cursor > fill) cursor = fill;
        end
        CMD_LEFT: begin
          if (cursor > 0) cursor--;
        end
        CMD_RIGHT: begin
          if (cursor < fill) cursor++;
        end
        CMD_HOME: cursor = 0;
        CMD_END:  cursor = fill;
        CMD_READ: begin
          if (idx < fill) begin
            st.byte_read = text_mem[idx];
            st.read_ok   = 1'b1;
            valid_reads++;
          end
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      st.length = LW'(fill);
      st.cursor = LW'(cursor);
      expected_status.push_back(st);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
                 $time, results_seen, name, want, got);
        errors++;
      end
    endfunction

    // Match one status transfer against the oldest pending one
    function void check_result(logic [OUT_W-1:0] data);
      edit_status_t got;
      edit_status_t want;
      got = data;
      if (expected_status.size() == 0) begin
        $display("%0t: status with no command pending: expected none, actual %h",
                 $time, data);
        errors++;
      end else begin
        want = expected_status.pop_front();
        results_seen++;
        compare_field("text_length", want.length, got.length);
        compare_field("cursor_pos", want.cursor, got.cursor);
        compare_field("rejected", want.refused, got.refused);
        compare_field("read_byte", want.byte_read, got.byte_read);
        compare_field("read_valid", want.read_ok, got.read_ok);
      end
    endfunction
  endclass

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  line_edit_tracker sb;
  logic        steady = 1'b0;
  int unsigned sent_cmds = 0;

  cursor_text_line_buffer_core #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Stall the result side at random unless in a steady stretch
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every status transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offer one command, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [AW-1:0] idx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - CMD_W - CHAR_W - AW){1'b0}}, idx, ch, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, ch, idx);
    sent_cmds++;
    @(negedge clk);
  endtask

  // Pick and send one random command; tells whether it was a defined code
  task automatic send_random(input stim_mode_t mode, output logic useful);
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [AW-1:0]     idx;
    int unsigned       r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 85)      cmd = CMD_INSERT;
        else if (r < 90) cmd = CMD_BKSP;
        else if (r < 94) cmd = CMD_LEFT;
        else if (r < 97) cmd = CMD_READ;
        else if (r < 98) cmd = CMD_RIGHT;
        else if (r < 99) cmd = CMD_HOME;
        else             cmd = CMD_END;
      end
      MODE_TYPE: begin
        if (r < 45)      cmd = CMD_INSERT;
        else if (r < 55) cmd = CMD_BKSP;
        else if (r < 61) cmd = CMD_DELETE;
        else if (r < 68) cmd = CMD_LEFT;
        else if (r < 75) cmd = CMD_RIGHT;
        else if (r < 79) cmd = CMD_HOME;
        else if (r < 83) cmd = CMD_END;
        else if (r < 97) cmd = CMD_READ;
        else             cmd = CMD_CLEAR;
      end
      default: begin
        if (r < 25)      cmd = CMD_INSERT;
        else if (r < 35) cmd = CMD_BKSP;
        else if (r < 48) cmd = CMD_DELETE;
        else if (r < 56) cmd = CMD_LEFT;
        else if (r < 64) cmd = CMD_RIGHT;
        else if (r < 69) cmd = CMD_HOME;
        else if (r < 74) cmd = CMD_END;
        else if (r < 96) cmd = CMD_READ;
        else             cmd = CMD_CLEAR;
      end
    endcase
    // mostly a small alphabet so delete-all finds matches
    r = $urandom_range(99);
    if (r < 55)      ch = 8'h61 + CHAR_W'($urandom_range(3));
    else if (r < 65) ch = $urandom_range(1) ? 8'hFF : 8'h00;
    else             ch = CHAR_W'($urandom_range(255));
    if (sb.fill > 0 && $urandom_range(3) != 0) idx = AW'($urandom_range(sb.fill - 1));
    else                                       idx = AW'($urandom_range(DEPTH - 1));
    // occasional noise: any code, any fields
    if ($urandom_range(99) < 6) begin
      cmd = CMD_W'($urandom_range(15));
      ch  = CHAR_W'($urandom_range(255));
      idx = AW'($urandom_range(DEPTH - 1));
    end
    useful = (cmd <= CMD_READ);
    send_command(cmd, ch, idx);
  endtask

  initial begin
    stim_mode_t  mode;
    logic        useful;
    int unsigned done;
    int unsigned phase;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-buffer edges, extreme bytes, shifts, reads, unused codes
    send_command(CMD_CLEAR, 8'h00, '0);
    send_command(CMD_BKSP, 8'h00, '0);
    send_command(CMD_LEFT, 8'h00, '0);
    send_command(CMD_RIGHT, 8'h00, '0);
    send_command(CMD_READ, 8'h00, 6'd0);
    send_command(CMD_DELETE, 8'h61, '0);
    send_command(CMD_INSERT, 8'h00, '0);
    send_command(CMD_INSERT, 8'hFF, 6'd63);
    send_command(CMD_INSERT, 8'h61, '0);
    send_command(CMD_HOME, 8'h00, '0);
    send_command(CMD_INSERT, 8'h62, '0);
    send_command(CMD_RIGHT, 8'h00, '0);
    send_command(CMD_READ, 8'h00, 6'd0);
    send_command(CMD_READ, 8'h00, 6'd3);
    send_command(CMD_READ, 8'h00, 6'd4);
    send_command(CMD_READ, 8'hFF, 6'd63);
    send_command(CMD_END, 8'h00, '0);
    send_command(CMD_RIGHT, 8'h00, '0);
    send_command(CMD_LEFT, 8'h00, '0);
    send_command(CMD_BKSP, 8'h00, '0);
    send_command(CMD_INSERT, 8'h61, '0);
    send_command(CMD_DELETE, 8'h61, '0);
    send_command(CMD_DELETE, 8'h7A, '0);
    send_command(4'd9, 8'hFF, 6'd63);
    send_command(4'd15, 8'h00, 6'd0);

    // Random: phases of typing, filling to capacity and editing
    done  = 0;
    phase = 0;
    while (done < RANDOM_CMDS) begin
      case (phase % 4)
        0:       mode = MODE_TYPE;
        1:       mode = MODE_FILL;
        2:       mode = MODE_EDIT;
        default: mode = MODE_FILL;
      endcase
      steady = (phase == 2);
      // hold off the sender until every status is back
      if (phase == 3) begin
        in_tvalid <= 1'b0;
        while (sb.expected_status.size() != 0) @(negedge clk);
      end
      for (int unsigned k = 0; k < PHASE_ITEMS && done < RANDOM_CMDS; ) begin
        send_random(mode, useful);
        if (useful) begin
          k++;
          done++;
        end
      end
      phase++;
    end
    steady    = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then let any late extra transfer show up
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands with %0d status words checked across typing, fill and edit phases.",
             sent_cmds, sb.results_seen);
    $display("Refused inserts %0d, valid reads %0d, delete-all passes with hits %0d, peak length %0d.",
             sb.refused_cnt, sb.valid_reads, sb.purge_hits, sb.peak_fill);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d status words still pending.", sb.expected_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[cursor_text_line_buffer_core.f]
+incdir+hw/rtl
hw/rtl/ctlb_pkg.sv
hw/rtl/ctlb_cell.sv
hw/rtl/ctlb_ctrl.sv
hw/rtl/cursor_text_line_buffer_core.sv
hw/rtl/ctlb_checker.sv
bench/tb.sv
